### sv/smks_pkg.sv
// shared types, constants and address helper for the knn select unit
`default_nettype none
package smks_pkg;

  localparam int MAX_DIM_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = 5;
  localparam int DIM_W       = 5;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } smks_entry_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic shl;
  } smks_cmd_t;

  // packed lower-triangular address of (a,b), symmetric in a and b
  function automatic logic [9:0] tri_addr(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] lo;
    logic [9:0]       p;
    hi = (a >= b) ? a : b;
    lo = (a >= b) ? b : a;
    p  = (10'(hi) * (10'(hi) + 10'd1)) >> 1;
    return p + 10'(lo);
  endfunction

endpackage
`default_nettype wire

### sv/symmetric_matrix_knn_select_unit.sv
// top level: symmetric distance store with k nearest neighbor selection
//
//   channel  direction  handshake           payload
//   cfg      in         cfg_write           cfg_data (dim_in_use)
//   in       in         in_valid/in_stall   mode row col value count
//   out      out        out_valid/out_stall neighbor_index status last
//
// a write, an out-of-range item or an empty query gives a single result straight from idle
// a query scans its row (one store read per cycle), then emits its results from the sorted chain
// after reset the store clears every entry while busy, and in_stall stays high until it is done
// results wait in an output register; a stalled output holds the emit sequence
`default_nettype none
module symmetric_matrix_knn_select_unit
  import smks_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [DIM_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             mode,
  input  wire logic [3:0]       row,
  input  wire logic [3:0]       col,
  input  wire logic [31:0]      value,
  input  wire logic [4:0]       count,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [3:0]       neighbor_index,
  output logic      [1:0]       status,
  output logic                  last
);

  localparam int DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int NCELL = MAX_DIM - 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t           state;
  logic [DIM_W-1:0] dim_in_use;
  logic [DIM_W-1:0] dim_eff;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] q_row;
  logic [DIM_W-1:0] n_left;
  logic             rd_ins;
  logic [IDX_W-1:0] rd_idx;

  logic             busy;
  logic [31:0]      rdata;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;

  logic             slot_free;
  logic             in_acc;
  logic             out_load;
  logic [DIM_W-1:0] row_x;
  logic [DIM_W-1:0] col_x;
  logic [DIM_W-1:0] avail;
  logic [DIM_W-1:0] n_req;
  logic             wr_bad;
  logic             q_bad;

  smks_cmd_t        cmd;
  smks_entry_t      new_ent;
  smks_entry_t      ent  [NCELL];
  logic             less [NCELL];

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_in_use <= '0;
    end else if (cfg_write) begin
      dim_in_use <= cfg_data;
    end
  end

  always_comb begin
    if (32'(dim_in_use) > MAX_DIM) begin
      dim_eff = DIM_W'(MAX_DIM);
    end else begin
      dim_eff = dim_in_use;
    end
  end

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) && !busy && slot_free);
  assign in_acc    = in_valid && !in_stall;

  assign row_x  = DIM_W'(row);
  assign col_x  = DIM_W'(col);
  assign wr_bad = (row_x >= dim_eff) || (col_x >= dim_eff);
  assign q_bad  = row_x >= dim_eff;
  assign avail  = dim_eff - DIM_W'(1);
  assign n_req  = (count < avail) ? count : avail;

  // a single-result transaction or the next emitted neighbor loads the output register
  assign out_load = (state == S_IDLE) ?
                    (in_acc && ((mode == MODE_WRITE) || q_bad || (n_req == '0))) :
                    ((state == S_EMIT) && slot_free);

  assign mem_we    = in_acc && (mode == MODE_WRITE) && !wr_bad;
  assign mem_waddr = AW'(tri_addr(IDX_W'(row), IDX_W'(col)));
  assign mem_re    = (state == S_SCAN);
  assign mem_raddr = AW'(tri_addr(q_row, scan_idx));

  smks_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata),
    .busy  (busy)
  );

  always_comb begin
    cmd.clr = in_acc && (mode == MODE_QUERY);
    cmd.ins = rd_ins;
    cmd.shl = (state == S_EMIT) && slot_free;
    new_ent.vld = 1'b1;
    new_ent.idx = rd_idx;
    new_ent.key = rdata;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    smks_entry_t prev_e;
    smks_entry_t next_e;
    logic        prev_l;
    if (i == 0) begin : g_first
      assign prev_e = new_ent;
      assign prev_l = 1'b0;
    end else begin : g_mid
      assign prev_e = ent[i-1];
      assign prev_l = less[i-1];
    end
    if (i == NCELL - 1) begin : g_end
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = ent[i+1];
    end
    smks_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .new_ent   (new_ent),
      .prev_ent  (prev_e),
      .prev_less (prev_l),
      .next_ent  (next_e),
      .cur       (ent[i]),
      .less      (less[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_ins    <= 1'b0;
    end else begin
      rd_ins <= (state == S_SCAN) && (scan_idx != q_row);
      rd_idx <= scan_idx;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (slot_free) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            neighbor_index <= '0;
            last           <= 1'b1;
            if (mode == MODE_WRITE) begin
              status <= wr_bad ? ST_RANGE : ST_OK;
            end else if (q_bad) begin
              status <= ST_RANGE;
            end else if (n_req == '0) begin
              status <= ST_EMPTY;
            end else begin
              q_row    <= IDX_W'(row);
              scan_idx <= '0;
              n_left   <= n_req;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + IDX_W'(1);
          if (DIM_W'(scan_idx) == avail) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            neighbor_index <= ent[0].idx[3:0];
            status         <= ST_OK;
            last           <= (n_left == DIM_W'(1));
            n_left         <= n_left - DIM_W'(1);
            if (n_left == DIM_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/smks_store.sv
// packed distance store with a clearing pass after reset
`default_nettype none
module smks_store #(
  parameter int DEPTH = 136,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata,
  output logic               busy
);

  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      if (clr_cnt == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/smks_cell.sv
// one cell of the sorted insertion chain
`default_nettype none
module smks_cell
  import smks_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire smks_cmd_t   cmd,
  input  wire smks_entry_t new_ent,
  input  wire smks_entry_t prev_ent,
  input  wire logic        prev_less,
  input  wire smks_entry_t next_ent,
  output smks_entry_t      cur,
  output logic             less
);

  // strict compare keeps earlier (lower index) entries ahead on ties
  assign less = !cur.vld || ($signed(new_ent.key) < $signed(cur.key));

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      cur.vld <= 1'b0;
    end else if (cmd.ins) begin
      if (less) begin
        cur <= prev_less ? prev_ent : new_ent;
      end
    end else if (cmd.shl) begin
      cur <= next_ent;
    end
  end

endmodule
`default_nettype wire
